@@ rtl/core/avdpx_pkg.sv @@
package avdpx_pkg;

    localparam int FLAG_W = 7;

    // event flag bit positions
    localparam int FL_FINISHED  = 0;
    localparam int FL_CONNECTED = 1;
    localparam int FL_CLOSED    = 2;
    localparam int FL_LINK      = 3;
    localparam int FL_APC       = 4;
    localparam int FL_L2        = 5;
    localparam int FL_ENTITY    = 6;

    localparam logic [9:0] ACCEPT_CODE  = 10'd200;
    localparam logic [7:0] NOP_INTV_RST = 8'd10;

    typedef enum logic [3:0] {
        K_TICK      = 4'd0,
        K_CONNECTED = 4'd1,
        K_CLOSED    = 4'd2,
        K_VERDICT   = 4'd3,
        K_LINK      = 4'd4,
        K_APC_MSG   = 4'd5,
        K_L2_MSG    = 4'd6,
        K_ENTITY    = 4'd7,
        K_FINISH    = 4'd8,
        K_CLEAR     = 4'd9
    } t_kind;

    typedef enum logic [2:0] {
        ACT_HTTP_RESP  = 3'd0,
        ACT_LINK_STAT  = 3'd1,
        ACT_TO_L2      = 3'd2,
        ACT_TO_APC     = 3'd3,
        ACT_ENT_ASSIGN = 3'd4,
        ACT_NOP        = 3'd5,
        ACT_CLOSE_CONN = 3'd6,
        ACT_CLOSE_SRV  = 3'd7
    } t_action;

    typedef enum logic [4:0] {
        ST_BEGIN,
        ST_INIT,
        ST_WAIT_CONN,
        ST_ACCEPT,
        ST_REJECT,
        ST_CLOSED,
        ST_START,
        ST_WAITING,
        ST_LINK,
        ST_TO_L2,
        ST_TO_APC,
        ST_ASSIGN,
        ST_NOP,
        ST_CLOSE_FIN,
        ST_FINISH,
        ST_HALT,
        ST_ACC_LINK     // second half of an accepted verdict: link status report
    } t_state;

    typedef enum logic {
        PH_IDLE,
        PH_RUN
    } t_phase;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_action     action;
        logic [9:0]  http_status;
        logic        link_up;
        logic [47:0] mac_address;
        logic [63:0] ent_id;
    } t_res;

endpackage

@@ rtl/core/avdpx_alu.sv @@
module avdpx_alu
    import avdpx_pkg::*;
(
    input  t_alu_op     i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a + i_b;
        endcase
    end

endmodule

@@ rtl/core/avdecc_proxy_server_fsm.sv @@
// Proxy-server control machine. Each event on the slave stream (kind in tuser) is applied
// when it is taken, then the machine takes one state transition per cycle until its state
// stops changing, unless an action is waiting on the master side or a keepalive deadline
// update is being made on the shared 32-bit adder/subtractor, which also makes the wrapped
// deadline compare. No new event is taken until the machine has settled.
// Actions come out in order on the master stream, tlast on the final one of each event;
// an event that causes no action produces no transfer. nop_interval is written through
// i_cfg_we/i_cfg_wdata; the user writes it only while the block is idle, which it does not enforce.
module avdecc_proxy_server_fsm
    import avdpx_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // time seconds, http status, link up, mac address, entity id, zero pad
    input  logic [159:0] s_axis_tdata,
    // kind
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // action, http status, link up, mac address, entity id, zero pad
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    t_phase            r_phase, n_phase;
    t_state            r_state, n_state;
    logic [FLAG_W-1:0] r_flags, n_flags;
    logic              r_vpend, n_vpend;
    logic [9:0]        r_vcode, n_vcode;
    logic [31:0]       r_now, n_now;
    logic [31:0]       r_dl, n_dl;
    logic              r_link, n_link;
    logic [47:0]       r_lmac, n_lmac;
    logic [47:0]       r_tmac, n_tmac;
    logic [63:0]       r_ent, n_ent;
    logic [7:0]        r_intv, n_intv;
    logic              r_rearm, n_rearm;
    logic              r_hold_v, n_hold_v;
    t_res              r_hold, n_hold;
    logic              r_out_v, n_out_v;
    logic              r_out_last, n_out_last;
    t_res              r_out, n_out;

    // one transition, computed from the current state
    t_state            st_ns;
    logic [FLAG_W-1:0] st_flags;
    logic              st_vpend;
    logic [31:0]       st_now;
    logic [31:0]       st_dl;
    logic              st_link;
    logic              st_rearm;
    logic              em_v;
    t_res              em;

    t_alu_op           alu_op;
    logic [31:0]       alu_a, alu_b, alu_y;

    logic              in_xfer;
    logic              out_free;
    logic              settled;
    logic              need_out;
    t_kind             in_kind;

    assign in_kind  = t_kind'(s_axis_tuser);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_v || m_axis_tready;

    // shared unit: deadline refresh or deadline-minus-now compare
    assign alu_op = r_rearm ? ALU_ADD : ALU_SUB;
    assign alu_a  = r_rearm ? r_now : r_dl;
    assign alu_b  = r_rearm ? {24'd0, r_intv} : r_now;

    avdpx_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    always_comb begin
        st_ns    = r_state;
        st_flags = r_flags;
        st_vpend = r_vpend;
        st_now   = r_now;
        st_dl    = r_dl;
        st_link  = r_link;
        st_rearm = 1'b0;
        em_v     = 1'b0;
        em       = '0;
        unique case (r_state)
            ST_BEGIN: begin
                st_ns = ST_INIT;
                st_flags[FL_APC]       = 1'b0;
                st_flags[FL_ENTITY]    = 1'b0;
                st_flags[FL_FINISHED]  = 1'b0;
                st_flags[FL_L2]        = 1'b0;
                st_flags[FL_CONNECTED] = 1'b0;
                st_now  = '0;
                st_link = 1'b0;
                st_dl   = '0;
            end
            ST_INIT: begin
                st_ns = ST_WAIT_CONN;
                st_flags[FL_CONNECTED] = 1'b0;
                st_flags[FL_CLOSED]    = 1'b0;
            end
            ST_WAIT_CONN: begin
                // finish wins over a pending connection
                if (r_flags[FL_FINISHED]) begin
                    st_ns     = ST_FINISH;
                    em_v      = 1'b1;
                    em.action = ACT_CLOSE_SRV;
                end else if (r_flags[FL_CONNECTED]) begin
                    st_ns    = ST_ACCEPT;
                    st_vpend = 1'b1;
                end
            end
            ST_ACCEPT: begin
                if (!r_vpend) begin
                    em_v           = 1'b1;
                    em.action      = ACT_HTTP_RESP;
                    em.http_status = r_vcode;
                    st_ns = (r_vcode == ACCEPT_CODE) ? ST_ACC_LINK : ST_REJECT;
                end
            end
            ST_ACC_LINK: begin
                st_ns          = ST_START;
                em_v           = 1'b1;
                em.action      = ACT_LINK_STAT;
                em.link_up     = r_link;
                em.mac_address = r_lmac;
                st_rearm       = 1'b1;
            end
            ST_REJECT: st_ns = ST_CLOSED;
            ST_CLOSED: begin
                em_v      = 1'b1;
                em.action = ACT_CLOSE_CONN;
                st_ns     = ST_WAIT_CONN;
                st_flags[FL_CONNECTED] = 1'b0;
                st_flags[FL_CLOSED]    = 1'b0;
            end
            ST_WAITING: begin
                if (r_flags[FL_CLOSED]) begin
                    st_ns = ST_CLOSED;
                end else if (r_flags[FL_FINISHED]) begin
                    st_ns     = ST_CLOSE_FIN;
                    em_v      = 1'b1;
                    em.action = ACT_CLOSE_CONN;
                end else if (r_flags[FL_LINK]) begin
                    st_ns          = ST_LINK;
                    em_v           = 1'b1;
                    em.action      = ACT_LINK_STAT;
                    em.link_up     = r_link;
                    em.mac_address = r_lmac;
                    st_rearm       = 1'b1;
                    st_flags[FL_LINK] = 1'b0;
                end else if (r_flags[FL_APC]) begin
                    st_ns     = ST_TO_L2;
                    em_v      = 1'b1;
                    em.action = ACT_TO_L2;
                    st_flags[FL_APC] = 1'b0;
                end else if (r_flags[FL_L2]) begin
                    st_ns     = ST_TO_APC;
                    em_v      = 1'b1;
                    em.action = ACT_TO_APC;
                    st_rearm  = 1'b1;
                    st_flags[FL_L2] = 1'b0;
                end else if (r_flags[FL_ENTITY]) begin
                    st_ns          = ST_ASSIGN;
                    em_v           = 1'b1;
                    em.action      = ACT_ENT_ASSIGN;
                    em.mac_address = r_tmac;
                    em.ent_id      = r_ent;
                    st_rearm       = 1'b1;
                    st_flags[FL_ENTITY] = 1'b0;
                end else if (alu_y[31]) begin
                    // deadline already passed, wrapped signed difference
                    st_ns     = ST_NOP;
                    em_v      = 1'b1;
                    em.action = ACT_NOP;
                    st_rearm  = 1'b1;
                end
            end
            ST_START, ST_LINK, ST_TO_L2, ST_TO_APC, ST_ASSIGN, ST_NOP: st_ns = ST_WAITING;
            ST_CLOSE_FIN: begin
                st_ns     = ST_FINISH;
                em_v      = 1'b1;
                em.action = ACT_CLOSE_SRV;
            end
            ST_FINISH: st_ns = ST_HALT;
            ST_HALT:   st_ns = ST_HALT;
            default:   st_ns = r_state;
        endcase
    end

    assign settled  = (st_ns == r_state);
    assign need_out = r_hold_v && (em_v || settled);

    always_comb begin
        n_phase    = r_phase;
        n_state    = r_state;
        n_flags    = r_flags;
        n_vpend    = r_vpend;
        n_vcode    = r_vcode;
        n_now      = r_now;
        n_dl       = r_dl;
        n_link     = r_link;
        n_lmac     = r_lmac;
        n_tmac     = r_tmac;
        n_ent      = r_ent;
        n_intv     = i_cfg_we ? i_cfg_wdata : r_intv;
        n_rearm    = r_rearm;
        n_hold_v   = r_hold_v;
        n_hold     = r_hold;
        n_out_v    = m_axis_tready ? 1'b0 : r_out_v;
        n_out_last = r_out_last;
        n_out      = r_out;

        if (in_xfer) begin
            n_phase = PH_RUN;
            case (in_kind)
                K_TICK:      n_now = s_axis_tdata[31:0];
                K_CONNECTED: n_flags[FL_CONNECTED] = 1'b1;
                K_CLOSED:    n_flags[FL_CLOSED] = 1'b1;
                K_VERDICT: begin
                    n_vcode = s_axis_tdata[41:32];
                    n_vpend = 1'b0;
                end
                K_LINK: begin
                    n_link = s_axis_tdata[42];
                    n_lmac = s_axis_tdata[90:43];
                    n_flags[FL_LINK] = 1'b1;
                end
                K_APC_MSG:   n_flags[FL_APC] = 1'b1;
                K_L2_MSG:    n_flags[FL_L2] = 1'b1;
                K_ENTITY: begin
                    n_tmac = s_axis_tdata[90:43];
                    n_ent  = s_axis_tdata[154:91];
                    n_flags[FL_ENTITY] = 1'b1;
                end
                K_FINISH:    n_flags[FL_FINISHED] = 1'b1;
                K_CLEAR: begin
                    n_state = ST_BEGIN;
                    n_flags = '0;
                    n_vpend = 1'b1;
                    n_now   = '0;
                    n_dl    = '0;
                    n_link  = 1'b0;
                end
                default: ;
            endcase
        end else if (r_phase == PH_RUN) begin
            if (r_rearm) begin
                n_dl    = alu_y;
                n_rearm = 1'b0;
            end else if (!need_out || out_free) begin
                n_state = st_ns;
                n_flags = st_flags;
                n_vpend = st_vpend;
                n_now   = st_now;
                n_dl    = st_dl;
                n_link  = st_link;
                n_rearm = st_rearm;
                if (em_v) begin
                    // held action is not the final one, pass it on
                    if (r_hold_v) begin
                        n_out      = r_hold;
                        n_out_last = 1'b0;
                        n_out_v    = 1'b1;
                    end
                    n_hold   = em;
                    n_hold_v = 1'b1;
                end
                if (settled) begin
                    if (r_hold_v) begin
                        n_out      = r_hold;
                        n_out_last = 1'b1;
                        n_out_v    = 1'b1;
                        n_hold_v   = 1'b0;
                    end
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_state  <= ST_BEGIN;
            r_flags  <= '0;
            r_vpend  <= 1'b1;
            r_vcode  <= '0;
            r_now    <= '0;
            r_dl     <= '0;
            r_link   <= 1'b0;
            r_lmac   <= '0;
            r_tmac   <= '0;
            r_ent    <= '0;
            r_intv   <= NOP_INTV_RST;
            r_rearm  <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_state  <= n_state;
            r_flags  <= n_flags;
            r_vpend  <= n_vpend;
            r_vcode  <= n_vcode;
            r_now    <= n_now;
            r_dl     <= n_dl;
            r_link   <= n_link;
            r_lmac   <= n_lmac;
            r_tmac   <= n_tmac;
            r_ent    <= n_ent;
            r_intv   <= n_intv;
            r_rearm  <= n_rearm;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign s_axis_tready = (r_phase == PH_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {2'b00, r_out.ent_id, r_out.mac_address, r_out.link_up,
                            r_out.http_status, r_out.action};

    // every event must flush its held action before the next one is taken
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_hold_v)
        else $error("held action left over while idle");

    a_rearm_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rearm |-> (r_phase == PH_RUN))
        else $error("deadline refresh pending outside of a run");

    a_event_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("event transfer did not start a run");

    a_hold_before_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_v) && !r_out_last) |-> r_hold_v)
        else $error("non-final action issued without a successor held");

endmodule
